// ----- src/two_level_cache_tag_controller_assert.svh -----
// Assertion macros used by the tag controller RTL.
`ifndef TWO_LEVEL_CACHE_TAG_CONTROLLER_ASSERT_SVH
`define TWO_LEVEL_CACHE_TAG_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TLCT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tag controller assertion failed");
`define TLCT_ASSERT_NORST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tag controller assertion failed");
`else
`define TLCT_ASSERT(lbl, clk, rst, prop)
`define TLCT_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ----- src/tlct_pkg.sv -----
`default_nettype none
package tlct_pkg;

   localparam int L1_SETS  = 64;
   localparam int L2_SETS  = 256;
   localparam int WAYS     = 8;
   localparam int L1_SET_W = 6;
   localparam int L2_SET_W = 8;
   localparam int WAY_W    = 3;

   localparam logic [1:0] CMD_ILOAD  = 2'd0;
   localparam logic [1:0] CMD_DLOAD  = 2'd1;
   localparam logic [1:0] CMD_STORE  = 2'd2;
   localparam logic [1:0] CMD_MODIFY = 2'd3;

   localparam logic [2:0] REG_L1_SET_BITS = 3'd0;
   localparam logic [2:0] REG_L1_WAYS     = 3'd1;
   localparam logic [2:0] REG_L1_OFFSET   = 3'd2;
   localparam logic [2:0] REG_L2_SET_BITS = 3'd3;
   localparam logic [2:0] REG_L2_WAYS     = 3'd4;
   localparam logic [2:0] REG_L2_OFFSET   = 3'd5;

   // One set of a tag store: all ways' tags, their valid bits and the FIFO pointer.
   typedef struct packed {
      logic [WAYS-1:0][31:0] tags;
      logic [WAYS-1:0]       vmask;
      logic [WAY_W-1:0]      ptr;
   } row_type;

   typedef struct packed {
      logic             hit;
      logic             ev;
      logic             wr;
      logic [WAY_W-1:0] way;
      row_type          row;
   } lvl_type;

   // Clamp a configured way count to the range 1 to 8.
   function automatic logic [3:0] eff_ways(logic [3:0] cfg);
      logic [3:0] r;
      if (cfg == 4'd0) r = 4'd1;
      else if (cfg > 4'(WAYS)) r = 4'(WAYS);
      else r = cfg;
      return r;
   endfunction

   // Compare one set against a tag and, on a load miss, build the refilled set.
   function automatic lvl_type lvl_lookup(row_type row, logic rv, logic [31:0] tag,
                                          logic [3:0] ways, logic load);
      lvl_type          r;
      logic [WAYS-1:0]  vm;
      logic [WAY_W-1:0] p;
      logic             found;
      vm = rv ? row.vmask : '0;
      p  = rv ? row.ptr : '0;
      r = '0;
      r.row = row;
      r.row.vmask = vm;
      r.row.ptr = p;
      found = 1'b0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if ((4'(w) < ways) && vm[w] && (row.tags[w] == tag)) begin
            r.hit = 1'b1;
            r.way = 3'(w);
         end
      end
      if (!r.hit && load) begin
         for (int w = WAYS - 1; w >= 0; w--) begin
            if ((4'(w) < ways) && !vm[w]) begin
               found = 1'b1;
               r.way = 3'(w);
            end
         end
         if (!found) begin
            if ({1'b0, p} >= ways) p = '0;
            r.way = p;
            r.ev = 1'b1;
            r.row.ptr = (({1'b0, p} + 4'd1) == ways) ? 3'd0 : p + 3'd1;
         end
         r.row.vmask[r.way] = 1'b1;
         r.row.tags[r.way] = tag;
         r.wr = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/tlct_ifs.sv -----
`default_nettype none
interface tlct_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] address;
   modport source (output valid, cmd, address, input ready);
   modport sink (input valid, cmd, address, output ready);
endinterface

interface tlct_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] access_kind;
   logic       l1_hit;
   logic       l1_evicted;
   logic [5:0] l1_set;
   logic [2:0] l1_way;
   logic       l2_hit;
   logic       l2_evicted;
   logic [7:0] l2_set;
   logic [2:0] l2_way;
   logic       last;
   modport source (output valid, access_kind, l1_hit, l1_evicted, l1_set, l1_way,
                   l2_hit, l2_evicted, l2_set, l2_way, last, input ready);
   modport sink (input valid, access_kind, l1_hit, l1_evicted, l1_set, l1_way,
                 l2_hit, l2_evicted, l2_set, l2_way, last, output ready);
endinterface
`default_nettype wire

// ----- src/two_level_cache_tag_controller.sv -----
// Timing: a request transfer reads the tag sets into registers (set read); the compare
// state then looks them up and, once the result register is free, registers the result.
// Ordering: a new request is taken only while the sequencer is idle, so one access finishes
// before the next is read; a modify runs a load pass, then a store pass, for its two results.
// Reset: synchronous, active high; clears the set-valid flags, the sequencer, the
// result valid flag and restores the configuration registers to their defaults.
`default_nettype none
`include "two_level_cache_tag_controller_assert.svh"
module two_level_cache_tag_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   tlct_req_if.sink         req_ch,
   tlct_rsp_if.source       rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_LOOK = 2'd2;

   // Configuration registers.
   logic [2:0] l1_sbits_ff;
   logic [3:0] l1_ways_ff, l1_off_ff, l2_sbits_ff, l2_ways_ff, l2_off_ff;
   logic [2:0] csr_idx;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx = csr_paddr[4:2];
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_sbits_ff <= 3'd0;
         l1_ways_ff  <= 4'd2;
         l1_off_ff   <= 4'd3;
         l2_sbits_ff <= 4'd1;
         l2_ways_ff  <= 4'd2;
         l2_off_ff   <= 4'd3;
      end else if (csr_wr) begin
         unique case (csr_idx)
            tlct_pkg::REG_L1_SET_BITS: l1_sbits_ff <= csr_pwdata[2:0];
            tlct_pkg::REG_L1_WAYS:     l1_ways_ff  <= csr_pwdata[3:0];
            tlct_pkg::REG_L1_OFFSET:   l1_off_ff   <= csr_pwdata[3:0];
            tlct_pkg::REG_L2_SET_BITS: l2_sbits_ff <= csr_pwdata[3:0];
            tlct_pkg::REG_L2_WAYS:     l2_ways_ff  <= csr_pwdata[3:0];
            tlct_pkg::REG_L2_OFFSET:   l2_off_ff   <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         tlct_pkg::REG_L1_SET_BITS: csr_prdata = {29'd0, l1_sbits_ff};
         tlct_pkg::REG_L1_WAYS:     csr_prdata = {28'd0, l1_ways_ff};
         tlct_pkg::REG_L1_OFFSET:   csr_prdata = {28'd0, l1_off_ff};
         tlct_pkg::REG_L2_SET_BITS: csr_prdata = {28'd0, l2_sbits_ff};
         tlct_pkg::REG_L2_WAYS:     csr_prdata = {28'd0, l2_ways_ff};
         tlct_pkg::REG_L2_OFFSET:   csr_prdata = {28'd0, l2_off_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // Sequencer state and the access being worked on.
   logic [1:0]  state_ff, state_in;
   logic [31:0] addr_ff;
   logic [1:0]  kind_ff;
   logic        modify_ff;
   logic        req_xfer, rd, commit;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rd = req_xfer || (state_ff == S_READ);

   // Address split for the set read; the address comes straight from the request
   // on a new transfer, and from the held copy on the store pass of a modify.
   logic [31:0] src_addr, sh1, sh2;
   logic [2:0]  l1_sb;
   logic [3:0]  l2_sb;
   logic [4:0]  l1_tsh, l2_tsh;
   logic [tlct_pkg::L1_SET_W-1:0] rd_l1set, l1set_ff;
   logic [tlct_pkg::L2_SET_W-1:0] rd_l2set, l2set_ff;
   logic [31:0] l1tag_ff, l2tag_ff;

   assign src_addr = (state_ff == S_IDLE) ? req_ch.address : addr_ff;
   assign l1_sb = (l1_sbits_ff > 3'd6) ? 3'd6 : l1_sbits_ff;
   assign l2_sb = (l2_sbits_ff > 4'd8) ? 4'd8 : l2_sbits_ff;
   assign sh1 = src_addr >> l1_off_ff;
   assign sh2 = src_addr >> l2_off_ff;
   assign rd_l1set = sh1[5:0] & 6'((7'd1 << l1_sb) - 7'd1);
   assign rd_l2set = sh2[7:0] & 8'((9'd1 << l2_sb) - 9'd1);
   assign l1_tsh = {1'b0, l1_off_ff} + {2'b0, l1_sb};
   assign l2_tsh = {1'b0, l2_off_ff} + {1'b0, l2_sb};

   // Tag memories, one row per set, plus a flag per set saying the row was written.
   tlct_pkg::row_type imem [tlct_pkg::L1_SETS];
   tlct_pkg::row_type dmem [tlct_pkg::L1_SETS];
   tlct_pkg::row_type umem [tlct_pkg::L2_SETS];
   tlct_pkg::row_type irow_ff, drow_ff, urow_ff;
   logic [tlct_pkg::L1_SETS-1:0] irv_ff, drv_ff;
   logic [tlct_pkg::L2_SETS-1:0] urv_ff;
   logic irvq_ff, drvq_ff, urvq_ff;
   logic iwe, dwe, uwe;

   // Lookup on the registered sets.
   tlct_pkg::lvl_type r1, r2;
   logic load;
   assign load = (kind_ff != tlct_pkg::CMD_STORE);
   always_comb begin
      if (kind_ff == tlct_pkg::CMD_ILOAD)
         r1 = tlct_pkg::lvl_lookup(irow_ff, irvq_ff, l1tag_ff,
                                   tlct_pkg::eff_ways(l1_ways_ff), load);
      else
         r1 = tlct_pkg::lvl_lookup(drow_ff, drvq_ff, l1tag_ff,
                                   tlct_pkg::eff_ways(l1_ways_ff), load);
      r2 = tlct_pkg::lvl_lookup(urow_ff, urvq_ff, l2tag_ff,
                                tlct_pkg::eff_ways(l2_ways_ff), load);
   end

   assign commit = (state_ff == S_LOOK) && (!rsp_ch.valid || rsp_ch.ready);
   assign iwe = commit && r1.wr && (kind_ff == tlct_pkg::CMD_ILOAD);
   assign dwe = commit && r1.wr && (kind_ff != tlct_pkg::CMD_ILOAD);
   assign uwe = commit && r2.wr;

   // A write lands at the end of the compare cycle; the next read of the same set
   // is issued no earlier than the following cycle, so it sees the new row.
   always_ff @(posedge clock) begin
      if (iwe) imem[l1set_ff] <= r1.row;
      if (rd) irow_ff <= imem[rd_l1set];
   end
   always_ff @(posedge clock) begin
      if (dwe) dmem[l1set_ff] <= r1.row;
      if (rd) drow_ff <= dmem[rd_l1set];
   end
   always_ff @(posedge clock) begin
      if (uwe) umem[l2set_ff] <= r2.row;
      if (rd) urow_ff <= umem[rd_l2set];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irv_ff <= '0;
         drv_ff <= '0;
         urv_ff <= '0;
      end else begin
         if (iwe) irv_ff[l1set_ff] <= 1'b1;
         if (dwe) drv_ff[l1set_ff] <= 1'b1;
         if (uwe) urv_ff[l2set_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd) begin
         irvq_ff  <= irv_ff[rd_l1set];
         drvq_ff  <= drv_ff[rd_l1set];
         urvq_ff  <= urv_ff[rd_l2set];
         l1set_ff <= rd_l1set;
         l2set_ff <= rd_l2set;
         l1tag_ff <= src_addr >> l1_tsh;
         l2tag_ff <= src_addr >> l2_tsh;
      end
      if (req_xfer) addr_ff <= req_ch.address;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_xfer) state_in = S_LOOK;
         S_READ: state_in = S_LOOK;
         S_LOOK: if (commit) state_in = modify_ff ? S_READ : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         modify_ff <= 1'b0;
         kind_ff   <= tlct_pkg::CMD_ILOAD;
      end else begin
         state_ff <= state_in;
         if (req_xfer) begin
            modify_ff <= (req_ch.cmd == tlct_pkg::CMD_MODIFY);
            kind_ff   <= (req_ch.cmd == tlct_pkg::CMD_MODIFY) ? tlct_pkg::CMD_DLOAD
                                                               : req_ch.cmd;
         end else if (commit && modify_ff) begin
            // The store pass of a modify follows its load pass.
            modify_ff <= 1'b0;
            kind_ff   <= tlct_pkg::CMD_STORE;
         end
      end
   end

   // Result register: it holds a finished result until the sink takes it.
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (commit) rsp_valid_ff <= 1'b1;
      else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
   end
   assign rsp_ch.valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ch.access_kind <= kind_ff;
         rsp_ch.l1_hit      <= r1.hit;
         rsp_ch.l1_evicted  <= r1.ev;
         rsp_ch.l1_set      <= l1set_ff;
         rsp_ch.l1_way      <= (r1.hit || r1.wr) ? r1.way : 3'd0;
         rsp_ch.l2_hit      <= r2.hit;
         rsp_ch.l2_evicted  <= r2.ev;
         rsp_ch.l2_set      <= l2set_ff;
         rsp_ch.l2_way      <= (r2.hit || r2.wr) ? r2.way : 3'd0;
         rsp_ch.last        <= !modify_ff;
      end
   end

   // An L1 result is never both a hit and an eviction.
   `TLCT_ASSERT(a_hit_ev, clock, reset, rsp_valid_ff |-> !(rsp_ch.l1_hit && rsp_ch.l1_evicted))
   // Stores never evict at either level.
   `TLCT_ASSERT(a_store_ev, clock, reset, (rsp_valid_ff && rsp_ch.access_kind == tlct_pkg::CMD_STORE) |-> (!rsp_ch.l1_evicted && !rsp_ch.l2_evicted))
   // The first result of a modify is a data load.
   `TLCT_ASSERT(a_mod_first, clock, reset, (rsp_valid_ff && !rsp_ch.last) |-> (rsp_ch.access_kind == tlct_pkg::CMD_DLOAD))
   // A new result only appears after a compare cycle.
   `TLCT_ASSERT(a_rsp_src, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_LOOK))

endmodule
`default_nettype wire
